// ===== src/mcbm_pkg.sv =====
// mcbm_pkg: types and constants of the multicart bank mapper with line irq
// holds item and result structs, register indexes and write decode codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcbm_pkg;

	localparam int CfgIndexWidth = 2;

	localparam logic [CfgIndexWidth-1:0] CFG_ALT_BOARD       = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_CHR_ROM_PRESENT = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_FOUR_SCREEN     = 2'd2;

	localparam logic KIND_CPU_WRITE = 1'b0;
	localparam logic KIND_LINE_TICK = 1'b1;

	localparam logic [15:0] ADDR_OUTER      = 16'h6000;
	localparam logic [15:0] ADDR_MASK       = 16'hE001;
	localparam logic [15:0] ADDR_CONTROL    = 16'h8000;
	localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
	localparam logic [15:0] ADDR_MIRROR     = 16'hA000;
	localparam logic [15:0] ADDR_OUTER_HI   = 16'hA001;
	localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
	localparam logic [15:0] ADDR_IRQ_ACK    = 16'hE000;

	localparam logic [7:0] FIXED_BASE_ALT  = 8'd6;
	localparam logic [7:0] FIXED_BASE_STD  = 8'd14;
	localparam logic [2:0] OUTER_SPECIAL   = 3'd2;
	localparam logic [2:0] OUTER_CLAMP_IN  = 3'd7;
	localparam logic [2:0] OUTER_CLAMP_OUT = 3'd6;
	localparam logic [8:0] CHR_OUTER_STEP  = 9'd128;

	typedef struct packed {
		logic        kind;
		logic [15:0] cpu_address;
		logic [7:0]  write_data;
		logic        line_rendering;
		logic [15:0] prg_lookup_address;
		logic [12:0] chr_lookup_address;
	} item_t;

	typedef struct packed {
		logic [8:0] prg_page;
		logic [8:0] chr_page;
		logic       irq_line;
		logic       mirror_horizontal;
	} result_t;

endpackage

`default_nettype wire

// ===== src/multicart_bank_mapper_with_line_irq.sv =====
// multicart_bank_mapper_with_line_irq: mmc3 style bank mapper, outer bank, line irq
// one input register stage, state update and page translation, one result register
// depends on mcbm_pkg
//
//  channel | direction | handshake           | payload
//  item    | in        | item_valid/stall    | mcbm_pkg::item_t
//  result  | out       | result_valid/stall  | mcbm_pkg::result_t
//  cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// an item passes the input register, then the result register; one item per cycle while the result side does not stall
// the mapper state updates as the item leaves the input register
// reset loads the power-on bank registers; no clearing pass
// item_stall rises only while both the input and result registers are full
// and the result side stalls; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module multicart_bank_mapper_with_line_irq (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  item_valid,
	output logic                                 item_stall,
	input  wire mcbm_pkg::item_t                 item,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output mcbm_pkg::result_t                    result,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [mcbm_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  wire                                  cfg_data
);
	import mcbm_pkg::*;

	logic        alt_board_q;
	logic        chr_rom_q;
	logic        four_screen_q;

	logic        s1_valid;
	item_t       item_s1;
	logic        advance;

	logic [7:0]  control_q, control_d;
	logic [2:0]  outer_q, outer_d;
	logic [7:0]  prg_regs_q [2];
	logic [7:0]  prg_regs_d [2];
	logic [7:0]  chr_regs_q [6];
	logic [7:0]  chr_regs_d [6];
	logic        irq_en_q, irq_en_d;
	logic [7:0]  irq_count_q, irq_count_d;
	logic [7:0]  irq_reload_q, irq_reload_d;
	logic        irq_q, irq_d;
	logic        mirror_q, mirror_d;

	logic [15:0] masked_addr;
	logic [7:0]  count_dec;
	logic [1:0]  prg_slot;
	logic [7:0]  fixed_base;
	logic [7:0]  prg_inner;
	logic [2:0]  chr_slot;
	logic [2:0]  chr_idx;
	logic [8:0]  chr_inner;
	result_t     result_d;

	assign cfg_ready  = 1'b1;
	assign advance    = s1_valid && !(result_valid && result_stall);
	assign item_stall = s1_valid && result_valid && result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_board_q   <= 1'b0;
			chr_rom_q     <= 1'b1;
			four_screen_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ALT_BOARD:       alt_board_q   <= cfg_data;
				CFG_CHR_ROM_PRESENT: chr_rom_q     <= cfg_data;
				CFG_FOUR_SCREEN:     four_screen_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!item_stall) begin
			s1_valid <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	// next mapper state
	assign masked_addr = item_s1.cpu_address & ADDR_MASK;
	assign count_dec   = irq_count_q - 8'd1;

	always_comb begin
		control_d    = control_q;
		outer_d      = outer_q;
		prg_regs_d   = prg_regs_q;
		chr_regs_d   = chr_regs_q;
		irq_en_d     = irq_en_q;
		irq_count_d  = irq_count_q;
		irq_reload_d = irq_reload_q;
		irq_d        = irq_q;
		mirror_d     = mirror_q;
		if (item_s1.kind == KIND_CPU_WRITE) begin
			if (item_s1.cpu_address == ADDR_OUTER) begin
				if (alt_board_q) begin
					outer_d = {1'b0, item_s1.write_data[2:1]};
				end else begin
					outer_d = {1'b0, item_s1.write_data[0], 1'b0};
				end
			end else if (item_s1.cpu_address[15]) begin
				unique case (masked_addr)
					ADDR_CONTROL: control_d = item_s1.write_data;
					ADDR_BANK_DATA: begin
						priority if (control_q[2:1] == 2'b00) begin
							chr_regs_d[control_q[2:0]] = {item_s1.write_data[7:1], 1'b0};
						end else if (control_q[2:1] == 2'b11) begin
							prg_regs_d[control_q[0]] = item_s1.write_data;
						end else begin
							chr_regs_d[control_q[2:0]] = item_s1.write_data;
						end
					end
					ADDR_MIRROR: begin
						if (!four_screen_q) mirror_d = item_s1.write_data[0];
					end
					ADDR_OUTER_HI: begin
						if (item_s1.write_data[2:0] == OUTER_CLAMP_IN) begin
							outer_d = OUTER_CLAMP_OUT;
						end else begin
							outer_d = item_s1.write_data[2:0];
						end
					end
					ADDR_IRQ_COUNT:  irq_count_d  = item_s1.write_data;
					ADDR_IRQ_RELOAD: irq_reload_d = item_s1.write_data;
					ADDR_IRQ_ACK: begin
						irq_en_d = 1'b0;
						irq_d    = 1'b0;
					end
					default: irq_en_d = 1'b1;
				endcase
			end
		end else if (item_s1.line_rendering && irq_en_q) begin
			if (count_dec == 8'd0) begin
				irq_count_d = irq_reload_q;
				irq_d       = 1'b1;
			end else begin
				irq_count_d = count_dec;
			end
		end
	end

	// page translation from the updated state
	assign prg_slot   = item_s1.prg_lookup_address[14:13];
	assign fixed_base = (alt_board_q && outer_d != OUTER_SPECIAL) ? FIXED_BASE_ALT
		: FIXED_BASE_STD;
	assign chr_slot   = item_s1.chr_lookup_address[12:10] ^ {control_d[7], 2'b00};
	assign chr_idx    = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};

	always_comb begin
		unique case (prg_slot)
			2'd1: prg_inner = prg_regs_d[1];
			2'd3: prg_inner = fixed_base + 8'd1;
			default: begin
				if ((prg_slot == 2'd0) != control_d[6]) begin
					prg_inner = prg_regs_d[0];
				end else begin
					prg_inner = fixed_base;
				end
			end
		endcase
	end

	always_comb begin
		chr_inner = {1'b0, chr_regs_d[chr_idx]};
		if (!chr_slot[2]) chr_inner = chr_inner + {8'd0, chr_slot[0]};
	end

	always_comb begin
		result_d.prg_page = {3'b000, outer_d, 3'b000} + {1'b0, prg_inner};
		result_d.chr_page = chr_rom_q ? (chr_inner + (outer_d[1] ? CHR_OUTER_STEP : 9'd0))
			: 9'd0;
		result_d.irq_line          = irq_d;
		result_d.mirror_horizontal = mirror_d;
	end

	// mapper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= 8'd0;
			outer_q       <= 3'd0;
			prg_regs_q[0] <= 8'd0;
			prg_regs_q[1] <= 8'd1;
			chr_regs_q[0] <= 8'd0;
			chr_regs_q[1] <= 8'd2;
			chr_regs_q[2] <= 8'd4;
			chr_regs_q[3] <= 8'd5;
			chr_regs_q[4] <= 8'd6;
			chr_regs_q[5] <= 8'd7;
			irq_en_q      <= 1'b0;
			irq_count_q   <= 8'd0;
			irq_reload_q  <= 8'd0;
			irq_q         <= 1'b0;
			mirror_q      <= 1'b0;
		end else if (advance) begin
			control_q    <= control_d;
			outer_q      <= outer_d;
			prg_regs_q   <= prg_regs_d;
			chr_regs_q   <= chr_regs_d;
			irq_en_q     <= irq_en_d;
			irq_count_q  <= irq_count_d;
			irq_reload_q <= irq_reload_d;
			irq_q        <= irq_d;
			mirror_q     <= mirror_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= result_d;
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		outer_q != OUTER_CLAMP_IN)
		else $error("outer bank holds the clamped code");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_q) |-> $past(advance && item_s1.kind == KIND_LINE_TICK))
		else $error("irq raised without a line tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == KIND_CPU_WRITE && item_s1.cpu_address[15]
			&& masked_addr == ADDR_IRQ_ACK) |=> (!irq_q && !irq_en_q))
		else $error("irq acknowledge did not clear irq and enable");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid && result_valid))
		else $error("input stalled while a register stage was free");

endmodule

`default_nettype wire

// ===== bench/multicart_bank_mapper_with_line_irq_tb.sv =====
// multicart_bank_mapper_with_line_irq_tb: self-checking bench for the multicart bank mapper
// a scoreboard class predicts page translation, mirroring and line irq for each transfer
// depends on mcbm_pkg and multicart_bank_mapper_with_line_irq
`timescale 1ns / 1ps

module multicart_bank_mapper_with_line_irq_tb;
	import mcbm_pkg::*;

	localparam logic [15:0] ADDR_IRQ_ENABLE = 16'hE001;
	localparam logic [15:0] ADDR_DECODE_FREE = 16'h1FFE;
	localparam logic [2:0] CHR_EVEN_SELS = 3'd2;
	localparam logic [2:0] PRG_SEL_FIRST = 3'd6;
	localparam int PRG_SWAP_BIT = 6;
	localparam int CHR_SWAP_BIT = 7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 119;
	localparam int SETTLE = 4;

	class mapper_scoreboard;
		bit alt_board;
		bit chr_rom;
		bit four_screen;
		logic [7:0] control;
		logic [2:0] outer;
		logic [7:0] prg_bank [2];
		logic [7:0] chr_bank [6];
		bit irq_en;
		bit irq_flag;
		bit mirror;
		logic [7:0] irq_cnt;
		logic [7:0] irq_rel;
		result_t page_queue[$];
		int errors;
		int checked;
		int irq_events;

		function new();
			alt_board = 1'b0;
			chr_rom = 1'b1;
			four_screen = 1'b0;
			control = '0;
			outer = '0;
			prg_bank[0] = 8'd0;
			prg_bank[1] = 8'd1;
			chr_bank[0] = 8'd0;
			chr_bank[1] = 8'd2;
			chr_bank[2] = 8'd4;
			chr_bank[3] = 8'd5;
			chr_bank[4] = 8'd6;
			chr_bank[5] = 8'd7;
			irq_en = 1'b0;
			irq_flag = 1'b0;
			mirror = 1'b0;
			irq_cnt = '0;
			irq_rel = '0;
			errors = 0;
			checked = 0;
			irq_events = 0;
		endfunction

		function void set_config(logic [CfgIndexWidth-1:0] idx, logic val);
			case (idx)
			CFG_ALT_BOARD: alt_board = val;
			CFG_CHR_ROM_PRESENT: chr_rom = val;
			CFG_FOUR_SCREEN: four_screen = val;
			default: ;
			endcase
		endfunction

		function logic [7:0] fixed_page(logic second);
			logic [7:0] base;
			base = (alt_board && outer != OUTER_SPECIAL) ? FIXED_BASE_ALT : FIXED_BASE_STD;
			return base + {7'd0, second};
		endfunction

		function logic [8:0] prg_page_of(logic [15:0] addr);
			logic [1:0] slot;
			logic [7:0] inner;
			slot = addr[14:13];
			case (slot)
			2'd1: inner = prg_bank[1];
			2'd3: inner = fixed_page(1'b1);
			default: begin
				inner = ((slot == 2'd0) != control[PRG_SWAP_BIT]) ? prg_bank[0] : fixed_page(1'b0);
			end
			endcase
			return {3'b000, outer, 3'b000} + {1'b0, inner};
		endfunction

		function logic [8:0] chr_page_of(logic [12:0] addr);
			logic [2:0] slot;
			logic [8:0] inner;
			if (!chr_rom)
				return '0;
			slot = addr[12:10];
			if (control[CHR_SWAP_BIT])
				slot[2] = ~slot[2];
			if (!slot[2])
				inner = {1'b0, chr_bank[slot[1]]} + {8'd0, slot[0]};
			else
				inner = {1'b0, chr_bank[slot - 3'd2]};
			return (outer[1] ? CHR_OUTER_STEP : 9'd0) + inner;
		endfunction

		function void cpu_write(logic [15:0] addr, logic [7:0] data);
			logic [2:0] sel;
			if (addr == ADDR_OUTER) begin
				outer = alt_board ? {1'b0, data[2:1]} : {1'b0, data[0], 1'b0};
				return;
			end
			if (!addr[15])
				return;
			case (addr & ADDR_MASK)
			ADDR_CONTROL: control = data;
			ADDR_BANK_DATA: begin
				sel = control[2:0];
				if (sel < PRG_SEL_FIRST)
					chr_bank[sel] = (sel < CHR_EVEN_SELS) ? {data[7:1], 1'b0} : data;
				else
					prg_bank[sel[0]] = data;
			end
			ADDR_MIRROR: begin
				if (!four_screen)
					mirror = data[0];
			end
			ADDR_OUTER_HI: outer = (data[2:0] == OUTER_CLAMP_IN) ? OUTER_CLAMP_OUT : data[2:0];
			ADDR_IRQ_COUNT: irq_cnt = data;
			ADDR_IRQ_RELOAD: irq_rel = data;
			ADDR_IRQ_ACK: begin
				irq_en = 1'b0;
				irq_flag = 1'b0;
			end
			default: irq_en = 1'b1;
			endcase
		endfunction

		function void note_transfer(item_t it);
			result_t want;
			if (it.kind == KIND_CPU_WRITE) begin
				cpu_write(it.cpu_address, it.write_data);
			end else if (it.line_rendering && irq_en) begin
				irq_cnt = irq_cnt - 8'd1;
				if (irq_cnt == 8'd0) begin
					irq_cnt = irq_rel;
					if (!irq_flag)
						irq_events++;
					irq_flag = 1'b1;
				end
			end
			want.prg_page = prg_page_of(it.prg_lookup_address);
			want.chr_page = chr_page_of(it.chr_lookup_address);
			want.irq_line = irq_flag;
			want.mirror_horizontal = mirror;
			page_queue.push_back(want);
		endfunction

		task report_mismatch(string what, int got_v, int want_v);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got_v, want_v);
			errors++;
		endtask

		task check_pages(result_t got);
			result_t want;
			if (page_queue.size() == 0) begin
				report_mismatch("result with nothing pending, prg_page", got.prg_page, 0);
				return;
			end
			want = page_queue.pop_front();
			checked++;
			if (got.prg_page !== want.prg_page)
				report_mismatch("prg_page", got.prg_page, want.prg_page);
			if (got.chr_page !== want.chr_page)
				report_mismatch("chr_page", got.chr_page, want.chr_page);
			if (got.irq_line !== want.irq_line)
				report_mismatch("irq_line", got.irq_line, want.irq_line);
			if (got.mirror_horizontal !== want.mirror_horizontal)
				report_mismatch("mirror_horizontal", got.mirror_horizontal, want.mirror_horizontal);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	mapper_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_items = 0;
	int n_settings = 0;

	multicart_bank_mapper_with_line_irq dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_pages(result);
	end

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_transfer(it);
		n_items++;
	endtask

	function automatic item_t lookup_item();
		item_t it;
		it = '0;
		if ($urandom_range(9) == 0)
			it.prg_lookup_address = 16'($urandom);
		else
			it.prg_lookup_address = 16'h8000 | 16'($urandom);
		it.chr_lookup_address = 13'($urandom);
		return it;
	endfunction

	task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
		item_t it;
		it = lookup_item();
		it.kind = KIND_CPU_WRITE;
		it.cpu_address = addr;
		it.write_data = data;
		it.line_rendering = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_tick(input logic rendering);
		item_t it;
		it = lookup_item();
		it.kind = KIND_LINE_TICK;
		it.cpu_address = 16'($urandom);
		it.write_data = 8'($urandom);
		it.line_rendering = rendering;
		send_item(it);
	endtask

	task automatic send_random_op();
		int pick;
		logic [15:0] noise;
		logic [7:0] irq_value;
		pick = $urandom_range(99);
		noise = ADDR_DECODE_FREE & 16'($urandom);
		irq_value = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
		if (pick < 35)
			send_tick($urandom_range(99) < 80);
		else if (pick < 45)
			send_write(ADDR_CONTROL | noise, 8'($urandom));
		else if (pick < 60)
			send_write(ADDR_BANK_DATA | noise, 8'($urandom));
		else if (pick < 65)
			send_write(ADDR_MIRROR | noise, 8'($urandom));
		else if (pick < 70)
			send_write(ADDR_OUTER_HI | noise, 8'($urandom));
		else if (pick < 75)
			send_write(ADDR_OUTER, 8'($urandom));
		else if (pick < 79)
			send_write(ADDR_IRQ_COUNT | noise, irq_value);
		else if (pick < 83)
			send_write(ADDR_IRQ_RELOAD | noise, irq_value);
		else if (pick < 87)
			send_write(ADDR_IRQ_ACK | noise, 8'($urandom));
		else if (pick < 93)
			send_write(ADDR_IRQ_ENABLE | noise, 8'($urandom));
		else
			send_write(16'($urandom), 8'($urandom));
	endtask

	task automatic drain(input int settle);
		item_valid <= 1'b0;
		while (sb.page_queue.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_config(idx, val);
	endtask

	task automatic apply_config(input logic alt, input logic rom, input logic four);
		write_reg(CFG_ALT_BOARD, alt);
		write_reg(CFG_CHR_ROM_PRESENT, rom);
		write_reg(CFG_FOUR_SCREEN, four);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		#2_000_000;
		$display("multicart_bank_mapper_with_line_irq regression: fail");
		$finish;
	end

	initial begin
		logic [2:0] setting;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_config(1'b0, 1'b1, 1'b0);

		// directed: bank selects, swaps, clamp, irq countdown, wrap and ignored writes
		send_write(ADDR_OUTER, 8'hFF);
		send_write(ADDR_CONTROL, 8'h46);
		send_write(ADDR_BANK_DATA, 8'hFF);
		send_write(ADDR_CONTROL, 8'h87);
		send_write(ADDR_BANK_DATA, 8'h80);
		send_write(ADDR_CONTROL, 8'h00);
		send_write(ADDR_BANK_DATA, 8'hFF);
		send_write(ADDR_CONTROL, 8'h01);
		send_write(ADDR_BANK_DATA, 8'h33);
		send_write(ADDR_CONTROL, 8'h05);
		send_write(ADDR_BANK_DATA, 8'hFF);
		send_write(ADDR_MIRROR, 8'h01);
		send_write(ADDR_OUTER_HI, 8'h07);
		send_write(ADDR_IRQ_COUNT, 8'h02);
		send_write(ADDR_IRQ_RELOAD, 8'h03);
		send_write(ADDR_IRQ_ENABLE, 8'h00);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_write(ADDR_IRQ_ACK, 8'h00);
		send_tick(1'b1);
		send_write(ADDR_IRQ_COUNT, 8'h00);
		send_write(ADDR_IRQ_ENABLE, 8'hFF);
		send_tick(1'b1);
		send_write(16'h7FFF, 8'hFF);
		send_write(16'h0000, 8'hFF);
		drain(SETTLE);

		for (int p = 0; p < PHASES; p++) begin
			setting = p[2:0];
			apply_config(setting[0], setting[1], setting[2]);
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 69;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 69;
			end
			default: begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off mid-phase until everything in flight has returned
				if (i == PHASE_ITEMS / 2)
					drain(1);
				send_random_op();
			end
			drain(SETTLE);
		end

		$display("covered %0d transfers over %0d mapper settings and four idle patterns",
			n_items, n_settings);
		$display("%0d results compared, %0d line interrupts raised", sb.checked, sb.irq_events);
		if (sb.errors == 0)
			$display("multicart_bank_mapper_with_line_irq regression: pass");
		else
			$display("multicart_bank_mapper_with_line_irq regression: fail");
		$finish;
	end

endmodule
